[hdl/mthtok_pkg.sv]
// mthtok_pkg: shared types and codes for the tag header tokenizer
// word formats of both channels, token kinds and error codes
// no dependencies
package mthtok_pkg;

  // most result words one header byte can give
  localparam int MAX_RES = 3;

  // token kinds
  localparam logic [2:0] KIND_NAME       = 3'd0;
  localparam logic [2:0] KIND_PARAM      = 3'd1;
  localparam logic [2:0] KIND_VALUE      = 3'd2;
  localparam logic [2:0] KIND_PARAM_DONE = 3'd3;
  localparam logic [2:0] KIND_OPEN_END   = 3'd4;
  localparam logic [2:0] KIND_SELF_END   = 3'd5;
  localparam logic [2:0] KIND_ERROR      = 3'd6;

  // error codes
  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd1;
  localparam logic [2:0] ERR_NO_NAME    = 3'd2;
  localparam logic [2:0] ERR_NO_PARAM   = 3'd3;
  localparam logic [2:0] ERR_NO_VALUE   = 3'd4;
  localparam logic [2:0] ERR_MISSING_GT = 3'd5;
  localparam logic [2:0] ERR_EARLY_END  = 3'd6;

  // input word
  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } in_t;

  // result word
  typedef struct packed {
    logic [2:0] token_kind;
    logic [7:0] char_out;
    logic [2:0] error_code;
    logic       last_result;
  } res_t;

  // all result words of one header byte, in order
  typedef struct packed {
    logic [1:0]              cnt;
    res_t [MAX_RES-1:0]      r;
  } step_out_t;

endpackage

[hdl/mthtok_step.sv]
// mthtok_step: comment filter and header tokenizer state with the
// single-pass logic that turns one byte into up to three result words
// depends on mthtok_pkg
module mthtok_step (
  input  logic                   clk,
  input  logic                   rst,
  input  mthtok_pkg::in_t        item,
  input  logic                   advance,
  output mthtok_pkg::step_out_t  res
);
  import mthtok_pkg::*;

  // characters of interest
  localparam logic [7:0] CH_TAB    = 8'd9;
  localparam logic [7:0] CH_LF     = 8'd10;
  localparam logic [7:0] CH_CR     = 8'd13;
  localparam logic [7:0] CH_SPACE  = 8'd32;
  localparam logic [7:0] CH_QUOTE  = 8'd34;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_COMMA  = 8'd44;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_DOT    = 8'd46;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_EQ     = 8'd61;
  localparam logic [7:0] CH_GT     = 8'd62;
  localparam logic [7:0] CH_BSLASH = 8'd92;

  typedef enum logic [2:0] {
    HP_NAME, HP_PARAM, HP_VALUE, HP_QUOTE, HP_WAIT
  } hphase_t;

  typedef enum logic [2:0] {
    FP_PLAIN, FP_BSLASH, FP_SLASH, FP_LINE, FP_BLOCK, FP_STAR
  } fphase_t;

  typedef struct packed {
    hphase_t hp;
    fphase_t fp;
    logic    egt;   // '/' separator seen, '>' must follow
    logic    acq;   // quoted value just closed
    logic    ns;
    logic    ps;
    logic    vs;
  } tstate_t;

  typedef struct packed {
    tstate_t   st;
    logic      over;
    step_out_t res;
  } ctx_t;

  localparam tstate_t ST_IDLE = '{HP_NAME, FP_PLAIN, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  tstate_t state;
  ctx_t    nxt;

  function automatic logic is_word(logic [7:0] ch);
    return (ch > 8'd47 && ch < 8'd58) || (ch > 8'd64 && ch < 8'd91) ||
           (ch > 8'd96 && ch < 8'd123) || ch == CH_DOT || ch == CH_COMMA ||
           ch == CH_DASH;
  endfunction

  function automatic logic is_sep(logic [7:0] ch);
    return ch == CH_TAB || ch == CH_SPACE || ch == CH_SLASH || ch == CH_GT;
  endfunction

  // append one result word, dropped once three are held
  function automatic ctx_t emit(ctx_t c, logic [2:0] kind, logic [7:0] ch,
                                logic [2:0] err);
    ctx_t n;
    n = c;
    if (c.res.cnt != 2'd3) begin
      n.res.r[c.res.cnt] = '{token_kind: kind, char_out: ch, error_code: err,
                             last_result: 1'b0};
      n.res.cnt = c.res.cnt + 2'd1;
    end
    return n;
  endfunction

  function automatic ctx_t finish(ctx_t c, logic [2:0] kind, logic [2:0] err);
    ctx_t n;
    n = emit(c, kind, 8'd0, err);
    n.over = 1'b1;
    return n;
  endfunction

  // tokenizer step for one filtered character
  function automatic ctx_t parse(ctx_t c, logic [7:0] ch, logic esc);
    ctx_t n;
    logic again;
    logic word;
    logic sep;
    logic stop;
    n = c;
    stop = 1'b0;
    word = !esc && is_word(ch);
    sep = !esc && is_sep(ch);
    if (!n.over) begin
      if (n.st.egt) begin
        if (!esc && ch == CH_GT) n = finish(n, KIND_SELF_END, ERR_NONE);
        else n = finish(n, KIND_ERROR, ERR_MISSING_GT);
        stop = 1'b1;
      end else if (n.st.acq) begin
        n.st.acq = 1'b0;
        if (!sep) begin
          n = finish(n, KIND_ERROR, ERR_UNEXPECTED);
          stop = 1'b1;
        end else if (!n.st.vs) begin
          n = finish(n, KIND_ERROR, ERR_NO_VALUE);
          stop = 1'b1;
        end else begin
          n = emit(n, KIND_PARAM_DONE, 8'd0, ERR_NONE);
          n.st.ps = 1'b0;
          n.st.vs = 1'b0;
          n.st.hp = HP_WAIT;
        end
      end
      // at most one re-entry: value end to wait, or wait to param
      again = !stop;
      for (int i = 0; i < 2; i++) begin
        if (again && !n.over) begin
          again = 1'b0;
          case (n.st.hp)
            HP_NAME: begin
              if (word) begin
                n = emit(n, KIND_NAME, ch, ERR_NONE);
                n.st.ns = 1'b1;
              end else if (!sep) n = finish(n, KIND_ERROR, ERR_UNEXPECTED);
              else if (!n.st.ns) n = finish(n, KIND_ERROR, ERR_NO_NAME);
              else begin
                n.st.hp = HP_WAIT;
                if (ch == CH_SLASH) n.st.egt = 1'b1;
                else if (ch == CH_GT) n = finish(n, KIND_OPEN_END, ERR_NONE);
              end
            end
            HP_PARAM: begin
              if (word) begin
                n = emit(n, KIND_PARAM, ch, ERR_NONE);
                n.st.ps = 1'b1;
              end else if (esc || ch != CH_EQ) n = finish(n, KIND_ERROR, ERR_UNEXPECTED);
              else if (!n.st.ps) n = finish(n, KIND_ERROR, ERR_NO_PARAM);
              else n.st.hp = HP_VALUE;
            end
            HP_VALUE: begin
              if (word) begin
                n = emit(n, KIND_VALUE, ch, ERR_NONE);
                n.st.vs = 1'b1;
              end else if (!esc && ch == CH_QUOTE) begin
                if (n.st.vs) n = finish(n, KIND_ERROR, ERR_UNEXPECTED);
                else n.st.hp = HP_QUOTE;
              end else if (sep) begin
                if (!n.st.vs) n = finish(n, KIND_ERROR, ERR_NO_VALUE);
                else begin
                  n = emit(n, KIND_PARAM_DONE, 8'd0, ERR_NONE);
                  n.st.ps = 1'b0;
                  n.st.vs = 1'b0;
                  n.st.hp = HP_WAIT;
                  again = 1'b1;
                end
              end else n = finish(n, KIND_ERROR, ERR_UNEXPECTED);
            end
            HP_QUOTE: begin
              if (esc) begin
                n = emit(n, KIND_VALUE, CH_QUOTE, ERR_NONE);
                n.st.vs = 1'b1;
              end else if (ch == CH_QUOTE) n.st.acq = 1'b1;
              else if (word || sep) begin
                n = emit(n, KIND_VALUE, ch, ERR_NONE);
                n.st.vs = 1'b1;
              end else n = finish(n, KIND_ERROR, ERR_UNEXPECTED);
            end
            default: begin
              if (word) begin
                n.st.hp = HP_PARAM;
                again = 1'b1;
              end else if (!esc && ch == CH_SLASH) n.st.egt = 1'b1;
              else if (!esc && ch == CH_GT) n = finish(n, KIND_OPEN_END, ERR_NONE);
              else if (!sep) n = finish(n, KIND_ERROR, ERR_UNEXPECTED);
            end
          endcase
        end
      end
    end
    return n;
  endfunction

  // filter byte outside any comment or escape
  function automatic ctx_t plain_byte(ctx_t c, logic [7:0] b);
    ctx_t n;
    n = c;
    if (b == CH_BSLASH) n.st.fp = FP_BSLASH;
    else if (b == CH_SLASH) n.st.fp = FP_SLASH;
    else n = parse(n, b, 1'b0);
    return n;
  endfunction

  // whole step: filter, tokenizer, end of input, last-word marking
  always_comb begin
    nxt.st = state;
    nxt.over = 1'b0;
    nxt.res = '0;
    case (state.fp)
      FP_PLAIN: nxt = plain_byte(nxt, item.byte_in);
      FP_BSLASH: begin
        nxt.st.fp = FP_PLAIN;
        if (item.byte_in == CH_QUOTE) nxt = parse(nxt, CH_QUOTE, 1'b1);
        else nxt = finish(nxt, KIND_ERROR, ERR_UNEXPECTED);
      end
      FP_SLASH: begin
        if (item.byte_in == CH_SLASH) nxt.st.fp = FP_LINE;
        else if (item.byte_in == CH_STAR) nxt.st.fp = FP_BLOCK;
        else begin
          // pending slash goes to the tokenizer before this byte
          nxt.st.fp = FP_PLAIN;
          nxt = parse(nxt, CH_SLASH, 1'b0);
          if (!nxt.over) nxt = plain_byte(nxt, item.byte_in);
        end
      end
      FP_LINE: begin
        if (item.byte_in == CH_LF || item.byte_in == CH_CR) nxt.st.fp = FP_PLAIN;
      end
      FP_BLOCK: begin
        if (item.byte_in == CH_STAR) nxt.st.fp = FP_STAR;
      end
      default: begin
        if (item.byte_in == CH_SLASH) nxt.st.fp = FP_PLAIN;
        else if (item.byte_in != CH_STAR) nxt.st.fp = FP_BLOCK;
      end
    endcase
    if (item.end_of_input && !nxt.over) nxt = finish(nxt, KIND_ERROR, ERR_EARLY_END);
    if (nxt.over || item.end_of_input) nxt.st = ST_IDLE;
    for (int i = 0; i < MAX_RES; i++) begin
      nxt.res.r[i].last_result = (2'(i) == nxt.res.cnt - 2'd1);
    end
  end

  assign res = nxt.res;

  // tokenizer and filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else if (advance) begin
      state <= nxt.st;
    end
  end

endmodule

[hdl/mthtok_outbuf.sv]
// mthtok_outbuf: three-word result buffer that drains one word a cycle while
// tok_stall is low and takes all words of the next byte once it is empty or emptying
// depends on mthtok_pkg
module mthtok_outbuf (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load_req,
  input  mthtok_pkg::step_out_t  res,
  output logic                   load_ok,
  output logic                   tok_valid,
  input  logic                   tok_stall,
  output mthtok_pkg::res_t       tok_word
);
  import mthtok_pkg::*;

  res_t [MAX_RES-1:0] slot;
  logic [1:0]         count;
  logic               pop;

  assign pop = (count != 2'd0) && !tok_stall;

  // a byte with no words never waits; otherwise the buffer must free up
  assign load_ok = (res.cnt == 2'd0) || (count == 2'd0) ||
                   (count == 2'd1 && pop);

  assign tok_valid = (count != 2'd0);
  assign tok_word  = slot[0];

  // fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (load_req && load_ok && res.cnt != 2'd0) begin
      count <= res.cnt;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  // word slots, head at slot 0
  always_ff @(posedge clk) begin
    if (load_req && load_ok && res.cnt != 2'd0) begin
      slot <= res.r;
    end else if (pop) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        slot[i] <= slot[i+1];
      end
    end
  end

endmodule

[hdl/markup_tag_header_tokenizer_unit.sv]
// Tag header tokenizer, top level.
// Input channel hdr_*: one byte of a tag header (the bytes after '<') per
// word, with end_of_input marking the last byte of the stream. Output
// channel tok_*: one token word per transfer; a byte gives zero to three
// words, last_result marks the last word of a byte.
// A byte taken is held in the input register; its words enter the result
// buffer once the buffer can take them (hdr_stall low), and the head word
// is driven from buffer slot 0.
// Throughput: one byte per cycle while each byte gives at most one word and
// tok_stall stays low; a byte that gives more words holds the next byte
// until the single output port drains the three-word buffer to one word.
// Reset (rst, synchronous): buffers empty, tokenizer waits for a tag name
// with the comment filter in pass-through.
// A stall on tok_* keeps the head word steady; once the buffer cannot take
// the next byte's words, hdr_stall rises and the input register holds.
// depends on mthtok_pkg, mthtok_step, mthtok_outbuf
module markup_tag_header_tokenizer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               hdr_valid,
  output logic               hdr_stall,
  input  mthtok_pkg::in_t    hdr_word,
  output logic               tok_valid,
  input  logic               tok_stall,
  output mthtok_pkg::res_t   tok_word
);
  import mthtok_pkg::*;

  logic      iv;
  in_t       ibuf;
  logic      load_ok;
  logic      consume;
  step_out_t res;

  assign consume   = iv && load_ok;
  assign hdr_stall = iv && !load_ok;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else if (hdr_valid && !hdr_stall) begin
      iv <= 1'b1;
    end else if (consume) begin
      iv <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_valid && !hdr_stall) begin
      ibuf <= hdr_word;
    end
  end

  // byte to tokens
  mthtok_step u_step (
    .clk     (clk),
    .rst     (rst),
    .item    (ibuf),
    .advance (consume),
    .res     (res)
  );

  // result buffer
  mthtok_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .load_req  (iv),
    .res       (res),
    .load_ok   (load_ok),
    .tok_valid (tok_valid),
    .tok_stall (tok_stall),
    .tok_word  (tok_word)
  );

endmodule

[hdl/mthtok_check.sv]
// mthtok_check: port-level checks for the tag header tokenizer
// bound to markup_tag_header_tokenizer_unit; depends on mthtok_pkg
module mthtok_check (
  input logic              clk,
  input logic              rst,
  input logic              hdr_valid,
  input logic              hdr_stall,
  input mthtok_pkg::in_t   hdr_word,
  input logic              tok_valid,
  input logic              tok_stall,
  input mthtok_pkg::res_t  tok_word
);
  import mthtok_pkg::*;

  // reset empties both stages
  a_reset_empty: assert property (@(posedge clk) rst |=> !tok_valid && !hdr_stall)
    else $error("words left after reset");

  // a stalled input word stays put
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    hdr_valid && hdr_stall |=> hdr_valid && $stable(hdr_word))
    else $error("stalled input word changed");

  // a stalled output word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid && $stable(tok_word))
    else $error("stalled output word changed");

  // input only backs up behind waiting output words
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    hdr_stall |-> tok_valid)
    else $error("input stalled with empty output");

  // char and error fields agree with the kind
  a_fields: assert property (@(posedge clk) disable iff (rst)
    tok_valid |-> (tok_word.token_kind == KIND_ERROR ?
                     (tok_word.error_code != ERR_NONE && tok_word.char_out == 8'd0) :
                     (tok_word.error_code == ERR_NONE &&
                      (tok_word.token_kind == KIND_NAME ||
                       tok_word.token_kind == KIND_PARAM ||
                       tok_word.token_kind == KIND_VALUE ||
                       tok_word.char_out == 8'd0))))
    else $error("token fields inconsistent");

endmodule

bind markup_tag_header_tokenizer_unit mthtok_check u_check (.*);
